### sv/ipk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipk_pkg
// Shared widths, register indexes and item types of the paddle keyer.
// ----------------------------------------------------------------------------
package ipk_pkg;

  localparam int unsigned PosW  = 20;
  localparam int unsigned SpdW  = 16;
  localparam int unsigned CntW  = 48;
  localparam int unsigned ThrW  = SpdW + 3;
  localparam int unsigned CfgW  = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned WordGapDits = 7;

  localparam logic [CfgIdxW-1:0] RegSamplesPerDit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDitLength     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDahLength     = 2'd2;

  localparam logic [SpdW-1:0] SamplesPerDitRst = 16'd2304;
  localparam logic [PosW-1:0] DitLengthRst     = 20'd4608;
  localparam logic [PosW-1:0] DahLengthRst     = 20'd9216;

  localparam logic [1:0] DoneNone = 2'd0;
  localparam logic [1:0] DoneDit  = 2'd1;
  localparam logic [1:0] DoneDah  = 2'd2;

  typedef struct packed {
    logic dit_pressed;
    logic dah_pressed;
    logic dit_latch;
    logic dah_latch;
  } in_item_t;

  typedef struct packed {
    logic            tone_on;
    logic [PosW-1:0] envelope_index;
    logic            element_kind;
    logic            word_space;
    logic [1:0]      element_done;
    logic            char_end;
  } out_item_t;

  typedef struct packed {
    logic [SpdW-1:0] dit_samples;
    logic [PosW-1:0] dit_element_length;
    logic [PosW-1:0] dah_element_length;
  } cfg_t;

endpackage

### sv/ipk_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipk_in_if / ipk_out_if
// Valid/ready channels carrying paddle items in and keyer results out.
// ----------------------------------------------------------------------------
interface ipk_in_if;
  logic              valid;
  logic              ready;
  ipk_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ipk_out_if;
  logic               valid;
  logic               ready;
  ipk_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### sv/iambic_paddle_keyer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iambic_paddle_keyer
// Iambic paddle keyer with dit and dah memories, one result per sample item.
// ----------------------------------------------------------------------------
// in_i carries one paddle item per audio sample (levels and press latches);
// out_o returns exactly one result per item: tone flag, envelope position,
// element kind, word-space flag, element-done code and character end.
// Configuration (samples per dit, dit and dah element lengths) is written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only
// while the keyer is idle, which the block itself does not enforce. An
// index beyond the register list is ignored. An item is captured in the
// input register on acceptance, is stepped through the sequencer into the
// result register and is offered on out_o from there. One item is accepted
// every cycle while out_o keeps taking results; each step completes an item.
// Reset clears the sequencer to idle, both memories, the idle counter and
// the registers to their defaults, and empties both pipeline registers.
// When out_o stalls the result register holds, the input register fills,
// and in_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module iambic_paddle_keyer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ipk_in_if.sink                        in_i,
  ipk_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [ipk_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipk_pkg::CfgW-1:0]      cfg_data_i
);

  ipk_pkg::cfg_t      cfg_q;
  logic               in_valid_q;
  ipk_pkg::in_item_t  in_item_q;
  logic               out_valid_q;
  ipk_pkg::out_item_t out_item_q;
  ipk_pkg::out_item_t res;
  logic               step;

  assign step        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || step;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dit_samples        <= ipk_pkg::SamplesPerDitRst;
      cfg_q.dit_element_length <= ipk_pkg::DitLengthRst;
      cfg_q.dah_element_length <= ipk_pkg::DahLengthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ipk_pkg::RegSamplesPerDit: begin
          cfg_q.dit_samples <= cfg_data_i[ipk_pkg::SpdW-1:0];
        end
        ipk_pkg::RegDitLength: begin
          cfg_q.dit_element_length <= cfg_data_i[ipk_pkg::PosW-1:0];
        end
        ipk_pkg::RegDahLength: begin
          cfg_q.dah_element_length <= cfg_data_i[ipk_pkg::PosW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.item;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  ipk_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

endmodule

### sv/ipk_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipk_seq
// Element sequencer: paddle memories, element position, word-gap timing.
// Produces one result per stepped item and updates state on step_i.
// ----------------------------------------------------------------------------
module ipk_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ipk_pkg::in_item_t  item_i,
  input  ipk_pkg::cfg_t      cfg_i,
  output ipk_pkg::out_item_t res_o
);

  typedef enum logic [1:0] {
    ELEM_IDLE = 2'd0,
    ELEM_DIT  = 2'd1,
    ELEM_DAH  = 2'd2
  } elem_e;

  elem_e                       elem_q, elem_d, cur_elem;
  logic [ipk_pkg::PosW-1:0]    pos_q, pos_d, cur_pos;
  logic                        dit_mem_q, dit_mem_d;
  logic                        dah_mem_q, dah_mem_d;
  logic [ipk_pkg::CntW-1:0]    idle_q, idle_d;
  logic                        ended_q, ended_d;

  logic                        dit_m, dah_m, start, is_dah, gap_word;
  logic [ipk_pkg::ThrW-1:0]    thr;
  logic [ipk_pkg::PosW:0]      next_pos;
  logic [ipk_pkg::PosW-1:0]    len;
  logic                        own_m, other_m;

  assign thr = ipk_pkg::ThrW'(ipk_pkg::WordGapDits)
             * ipk_pkg::ThrW'(cfg_i.dit_samples);
  assign gap_word = (idle_q[ipk_pkg::CntW-1:ipk_pkg::ThrW] != '0)
                  || (idle_q[ipk_pkg::ThrW-1:0] > thr);

  always_comb begin
    dit_m     = dit_mem_q | item_i.dit_latch;
    dah_m     = dah_mem_q | item_i.dah_latch;
    start     = (elem_q == ELEM_IDLE) && (dit_m || dah_m);
    cur_elem  = elem_q;
    cur_pos   = pos_q;
    if (start) begin
      cur_elem = dit_m ? ELEM_DIT : ELEM_DAH;
      cur_pos  = '0;
    end
    is_dah    = (cur_elem == ELEM_DAH);
    len       = is_dah ? cfg_i.dah_element_length : cfg_i.dit_element_length;
    next_pos  = {1'b0, cur_pos} + 21'd1;
    own_m     = 1'b0;
    other_m   = 1'b0;

    res_o     = '0;
    res_o.word_space = start && ended_q && gap_word;
    elem_d    = cur_elem;
    pos_d     = cur_pos;
    dit_mem_d = dit_m;
    dah_mem_d = dah_m;

    unique case (cur_elem) inside
      ELEM_DIT, ELEM_DAH: begin
        res_o.tone_on        = 1'b1;
        res_o.envelope_index = cur_pos;
        res_o.element_kind   = is_dah;
        if (next_pos >= {1'b0, len}) begin
          res_o.element_done = is_dah ? ipk_pkg::DoneDah : ipk_pkg::DoneDit;
          pos_d = '0;
          if (is_dah) begin
            dah_mem_d = dah_m & item_i.dah_pressed;
            own_m     = dah_mem_d;
            other_m   = dit_m;
          end else begin
            dit_mem_d = dit_m & item_i.dit_pressed;
            own_m     = dit_mem_d;
            other_m   = dah_m;
          end
          if (other_m) begin
            elem_d = is_dah ? ELEM_DIT : ELEM_DAH;
          end else if (!own_m) begin
            elem_d         = ELEM_IDLE;
            res_o.char_end = 1'b1;
          end
        end else begin
          pos_d = next_pos[ipk_pkg::PosW-1:0];
        end
      end
      default: begin
        elem_d = ELEM_IDLE;
      end
    endcase

    idle_d  = res_o.char_end ? ipk_pkg::CntW'(1) : idle_q + ipk_pkg::CntW'(1);
    ended_d = ended_q | res_o.char_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q    <= ELEM_IDLE;
      pos_q     <= '0;
      dit_mem_q <= 1'b0;
      dah_mem_q <= 1'b0;
      idle_q    <= '0;
      ended_q   <= 1'b0;
    end else if (step_i) begin
      elem_q    <= elem_d;
      pos_q     <= pos_d;
      dit_mem_q <= dit_mem_d;
      dah_mem_q <= dah_mem_d;
      idle_q    <= idle_d;
      ended_q   <= ended_d;
    end
  end

  a_char_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.char_end |-> res_o.element_done != ipk_pkg::DoneNone)
    else $error("char end without element done");

  a_word_space_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.word_space |-> res_o.tone_on && res_o.envelope_index == '0)
    else $error("word space off element start");

  a_char_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.char_end |=> elem_q == ELEM_IDLE && idle_q == 48'd1)
    else $error("state not idle after char end");

  a_silent_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !res_o.tone_on
      |-> res_o.element_done == ipk_pkg::DoneNone && !res_o.char_end)
    else $error("element done while silent");

endmodule

### sim/iambic_paddle_keyer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iambic_paddle_keyer_tb
// Self-checking bench for the iambic paddle keyer.
// ----------------------------------------------------------------------------
// Paddle items go in over the input channel. A scoreboard class steps its own
// copy of the keyer state for every accepted item and queues the result it
// should produce, then compares each result taken from the output channel
// field by field. The run starts at the reset register values and cuts an
// element short with a length change, walks through squeezes, held paddles
// and word-gap boundaries, hits the register extremes and then runs random
// keying over several small timing settings. Both channels idle at random,
// and a long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module iambic_paddle_keyer_tb;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned PhaseItems  = 280;
  localparam int unsigned ResetProbe  = 20;
  localparam int unsigned NarrowSpd   = 9363;
  localparam int unsigned NarrowGap   = 100;

  localparam logic [ipk_pkg::CfgIdxW-1:0] RegSpare = 2'd3;

  typedef enum logic [1:0] {
    KeyIdle = 2'd0,
    KeyDit  = 2'd1,
    KeyDah  = 2'd2
  } key_state_e;

  class keyer_scoreboard;
    logic [ipk_pkg::SpdW-1:0] spd;
    logic [ipk_pkg::PosW-1:0] dit_len;
    logic [ipk_pkg::PosW-1:0] dah_len;
    key_state_e               active;
    logic [ipk_pkg::PosW-1:0] pos;
    logic                     dit_mem;
    logic                     dah_mem;
    logic                     ended_before;
    logic [ipk_pkg::CntW-1:0] sample_cnt;
    logic [ipk_pkg::CntW-1:0] last_end;
    ipk_pkg::out_item_t       expected_q[$];
    int unsigned              accepted;
    int unsigned              results;
    int unsigned              mismatches;
    int unsigned              dits;
    int unsigned              dahs;
    int unsigned              chars;
    int unsigned              word_spaces;

    function new();
      spd          = ipk_pkg::SamplesPerDitRst;
      dit_len      = ipk_pkg::DitLengthRst;
      dah_len      = ipk_pkg::DahLengthRst;
      active       = KeyIdle;
      pos          = '0;
      dit_mem      = 1'b0;
      dah_mem      = 1'b0;
      ended_before = 1'b0;
      sample_cnt   = '0;
      last_end     = '0;
      accepted     = 0;
      results      = 0;
      mismatches   = 0;
      dits         = 0;
      dahs         = 0;
      chars        = 0;
      word_spaces  = 0;
    endfunction

    function void write_reg(logic [ipk_pkg::CfgIdxW-1:0] idx,
                            logic [ipk_pkg::CfgW-1:0] data);
      case (idx)
        ipk_pkg::RegSamplesPerDit: spd = data[ipk_pkg::SpdW-1:0];
        ipk_pkg::RegDitLength:     dit_len = data[ipk_pkg::PosW-1:0];
        ipk_pkg::RegDahLength:     dah_len = data[ipk_pkg::PosW-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(ipk_pkg::in_item_t it);
      ipk_pkg::out_item_t       r;
      logic [ipk_pkg::PosW:0]   nxt;
      logic [ipk_pkg::PosW-1:0] len;
      logic [ipk_pkg::CntW-1:0] idle_span;
      logic                     is_dah;
      logic                     own_mem;
      logic                     other_mem;
      r = '0;
      if (it.dit_latch) dit_mem = 1'b1;
      if (it.dah_latch) dah_mem = 1'b1;
      if (active == KeyIdle && (dit_mem || dah_mem)) begin
        idle_span = sample_cnt - last_end;
        r.word_space = ended_before &&
                       (64'(idle_span) > 64'(spd) * 64'(ipk_pkg::WordGapDits));
        active = dit_mem ? KeyDit : KeyDah;
        pos = '0;
      end
      if (active != KeyIdle) begin
        is_dah           = (active == KeyDah);
        len              = is_dah ? dah_len : dit_len;
        nxt              = {1'b0, pos} + 1'b1;
        r.tone_on        = 1'b1;
        r.envelope_index = pos;
        r.element_kind   = is_dah;
        if (nxt >= {1'b0, len}) begin
          r.element_done = is_dah ? ipk_pkg::DoneDah : ipk_pkg::DoneDit;
          pos = '0;
          if (is_dah) begin
            if (!it.dah_pressed) dah_mem = 1'b0;
            own_mem   = dah_mem;
            other_mem = dit_mem;
          end else begin
            if (!it.dit_pressed) dit_mem = 1'b0;
            own_mem   = dit_mem;
            other_mem = dah_mem;
          end
          if (other_mem) begin
            active = is_dah ? KeyDit : KeyDah;
          end else if (!own_mem) begin
            active       = KeyIdle;
            last_end     = sample_cnt;
            ended_before = 1'b1;
            r.char_end   = 1'b1;
          end
        end else begin
          pos = nxt[ipk_pkg::PosW-1:0];
        end
      end
      sample_cnt = sample_cnt + 1'b1;
      if (r.element_done == ipk_pkg::DoneDit) dits++;
      if (r.element_done == ipk_pkg::DoneDah) dahs++;
      if (r.char_end) chars++;
      if (r.word_space) word_spaces++;
      accepted++;
      expected_q.push_back(r);
    endfunction

    function bit keyer_idle();
      return active == KeyIdle;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH %0s", msg);
    endtask

    task compare_field(string name, logic [ipk_pkg::PosW-1:0] got,
                       logic [ipk_pkg::PosW-1:0] want);
      if (got !== want)
        report($sformatf("result %0d: %0s got %0d want %0d", results, name, got, want));
    endtask

    task check_result(ipk_pkg::out_item_t got);
      ipk_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results));
        return;
      end
      want = expected_q.pop_front();
      compare_field("tone_on", ipk_pkg::PosW'(got.tone_on),
                    ipk_pkg::PosW'(want.tone_on));
      compare_field("envelope_index", got.envelope_index, want.envelope_index);
      compare_field("element_kind", ipk_pkg::PosW'(got.element_kind),
                    ipk_pkg::PosW'(want.element_kind));
      compare_field("word_space", ipk_pkg::PosW'(got.word_space),
                    ipk_pkg::PosW'(want.word_space));
      compare_field("element_done", ipk_pkg::PosW'(got.element_done),
                    ipk_pkg::PosW'(want.element_done));
      compare_field("char_end", ipk_pkg::PosW'(got.char_end),
                    ipk_pkg::PosW'(want.char_end));
      results++;
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ipk_pkg::CfgIdxW-1:0]   cfg_idx;
  logic [ipk_pkg::CfgW-1:0]      cfg_data;

  ipk_in_if  in_if ();
  ipk_out_if out_if ();

  iambic_paddle_keyer dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  keyer_scoreboard sb = new();

  bit          tx_quiet = 1'b1;
  bit          rx_quiet = 1'b1;
  int unsigned hold_seq = 0;
  int unsigned cycles = 0;
  int unsigned settings = 0;
  int unsigned cur_spd = ipk_pkg::SamplesPerDitRst;
  int unsigned cur_dit = ipk_pkg::DitLengthRst;
  int unsigned cur_dah = ipk_pkg::DahLengthRst;

  // dit 2, dah 3, one sample per dit: squeeze, held dah with a dit tap,
  // gap one short of a word space, then a gap one past it
  logic [3:0] directed_seq [29] = '{
    4'b1111, 4'b0100, 4'b0100, 4'b0100, 4'b0000,
    4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
    4'b0101, 4'b0100, 4'b1110, 4'b1000, 4'b0000,
    4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
    4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
    4'b1010, 4'b1000, 4'b0000
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.item);
  end

  initial begin : receiver
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned stall_left;
    hold_seen    = 0;
    hold_left    = 0;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
        if (out_if.valid) stall_left = rx_quiet ? 0 : $urandom_range(0, 3);
      end
    end
  end

  task automatic send_item(input ipk_pkg::in_item_t it);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_zeros(input int unsigned n);
    repeat (n) send_item('0);
  endtask

  task automatic settle();
    while (!sb.keyer_idle()) send_item('0);
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ipk_pkg::CfgIdxW-1:0] idx,
                           input logic [ipk_pkg::CfgW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic program_keyer(input int unsigned spd, input int unsigned dit,
                               input int unsigned dah);
    quiesce();
    write_reg(ipk_pkg::RegSamplesPerDit, ipk_pkg::CfgW'(spd));
    write_reg(ipk_pkg::RegDitLength, ipk_pkg::CfgW'(dit));
    write_reg(ipk_pkg::RegDahLength, ipk_pkg::CfgW'(dah));
    cur_spd = spd;
    cur_dit = dit;
    cur_dah = dah;
    settings++;
  endtask

  // one keying gesture: dit, dah or squeeze, with occasional garbled paddle bits
  task automatic key_sequence();
    int unsigned span;
    int unsigned dit_from;
    int unsigned dah_from;
    int unsigned dit_hold;
    int unsigned dah_hold;
    int unsigned seq_len;
    bit          use_dit;
    bit          use_dah;
    bit          broken;
    logic [3:0]  b;
    span = cur_dit + cur_dah;
    case ($urandom_range(0, 2))
      0: begin
        use_dit = 1'b1;
        use_dah = 1'b0;
      end
      1: begin
        use_dit = 1'b0;
        use_dah = 1'b1;
      end
      default: begin
        use_dit = 1'b1;
        use_dah = 1'b1;
      end
    endcase
    dit_from = $urandom_range(0, cur_dit);
    dah_from = $urandom_range(0, cur_dit);
    dit_hold = $urandom_range(1, span);
    dah_hold = $urandom_range(1, span);
    broken   = ($urandom_range(0, 5) == 0);
    seq_len  = 0;
    if (use_dit) seq_len = dit_from + dit_hold;
    if (use_dah && dah_from + dah_hold > seq_len) seq_len = dah_from + dah_hold;
    for (int t = 0; t < seq_len; t++) begin
      b[3] = use_dit && t >= dit_from && t < dit_from + dit_hold;
      b[2] = use_dah && t >= dah_from && t < dah_from + dah_hold;
      b[1] = use_dit && t == dit_from;
      b[0] = use_dah && t == dah_from;
      if (broken && $urandom_range(0, 2) == 0) b = b ^ 4'($urandom_range(1, 15));
      send_item(ipk_pkg::in_item_t'(b));
    end
    send_zeros($urandom_range(0, 8 * cur_spd + 2));
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned start;
    start    = sb.accepted;
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    hold_seq++;
    while (sb.accepted - start < quota) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 12))
          send_item(ipk_pkg::in_item_t'(4'($urandom_range(0, 15))));
      end else begin
        key_sequence();
      end
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
    end
    settle();
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.item  = '0;
    cfg_we      = 1'b0;
    cfg_idx     = ipk_pkg::RegSamplesPerDit;
    cfg_data    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: a dit starts at the default length, then a shorter
    // length ends it mid-element
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_item(ipk_pkg::in_item_t'(4'b1010));
    send_zeros(ResetProbe);
    program_keyer(ipk_pkg::SamplesPerDitRst, 8, 12);
    settle();

    program_keyer(1, 2, 3);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    foreach (directed_seq[i]) send_item(ipk_pkg::in_item_t'(directed_seq[i]));
    settle();

    // register extremes; only the short element is keyed
    program_keyer(16'hFFFF, 1, 20'hFFFFF);
    send_item(ipk_pkg::in_item_t'(4'b1010));
    send_item(ipk_pkg::in_item_t'(4'b0000));
    send_item(ipk_pkg::in_item_t'(4'b1010));
    send_item(ipk_pkg::in_item_t'(4'b1000));
    send_item(ipk_pkg::in_item_t'(4'b0010));
    send_item(ipk_pkg::in_item_t'(4'b1000));
    send_zeros(40);
    send_item(ipk_pkg::in_item_t'(4'b1010));
    settle();
    quiesce();
    write_reg(RegSpare, 20'hFFFFF);

    // threshold past 16 bits: a gap that a narrow compare would call a word
    program_keyer(NarrowSpd, 20'hFFFFF, 1);
    tx_quiet = 1'b1;
    send_item(ipk_pkg::in_item_t'(4'b0101));
    send_zeros(NarrowGap);
    send_item(ipk_pkg::in_item_t'(4'b0101));
    send_item(ipk_pkg::in_item_t'(4'b0000));
    settle();

    program_keyer(1, 1, 1);
    random_phase(PhaseItems);
    repeat (4) begin
      program_keyer($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(2, 12));
      random_phase(PhaseItems);
    end

    quiesce();
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("ran %0d sample items over %0d register settings, %0d results checked",
             sb.accepted, settings, sb.results);
    $display("keyed %0d dits, %0d dahs, %0d characters, %0d word spaces",
             sb.dits, sb.dahs, sb.chars, sb.word_spaces);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/ipk_pkg.sv
sv/ipk_if.sv
sv/ipk_seq.sv
sv/iambic_paddle_keyer.sv
sim/iambic_paddle_keyer_tb.sv
